/* rtl/plob_pkg.sv */
// Shared types and constants of the price-level order book.
package plob_pkg;

    localparam int LEVELS_DEF = 64;

    localparam int PRICE_W = 64;
    localparam int QTY_W   = 32;
    localparam int LVL_W   = 7;
    localparam int VOL_W   = 64;

    typedef enum logic [2:0] {
        MODE_SET_BID = 3'd0,
        MODE_SET_ASK = 3'd1,
        MODE_DEL_BID = 3'd2,
        MODE_DEL_ASK = 3'd3,
        MODE_TRADE   = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        STAT_APPLIED = 2'd0,
        STAT_FULL    = 2'd1,
        STAT_NONE    = 2'd2
    } status_t;

    // Per-side operation selected from the mode.
    typedef enum logic [1:0] {
        SIDE_IDLE = 2'd0,
        SIDE_SET  = 2'd1,
        SIDE_DEL  = 2'd2
    } side_op_t;

    // What every cell of a side does at the update edge.
    typedef enum logic [1:0] {
        ACT_HOLD = 2'd0,
        ACT_UPD  = 2'd1,
        ACT_INS  = 2'd2,
        ACT_DEL  = 2'd3
    } cell_act_t;

    typedef enum logic {
        FSM_IDLE  = 1'b0,
        FSM_APPLY = 1'b1
    } fsm_t;

    typedef struct packed {
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   qty;
    } entry_t;

    // Broadcast from a side's control to all of its cells.
    typedef struct packed {
        cell_act_t act;
        entry_t    item;
    } cell_ctl_t;

endpackage

/* rtl/plob_in_if.sv */
// Input channel: one book update or trade per beat.
interface plob_in_if;
    import plob_pkg::*;

    logic               valid;
    logic               ready;
    logic [2:0]         mode;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   quantity;

    modport source (output valid, output mode, output price, output quantity, input ready);
    modport sink   (input valid, input mode, input price, input quantity, output ready);
endinterface

/* rtl/plob_out_if.sv */
// Output channel: one book snapshot per beat.
interface plob_out_if;
    import plob_pkg::*;

    logic               valid;
    logic               ready;
    logic [PRICE_W-1:0] best_bid;
    logic [PRICE_W-1:0] best_ask;
    logic [LVL_W-1:0]   bid_levels;
    logic [LVL_W-1:0]   ask_levels;
    logic [PRICE_W-1:0] last_trade;
    logic [VOL_W-1:0]   volume;
    logic [1:0]         status;

    modport source (output valid, output best_bid, output best_ask, output bid_levels,
                    output ask_levels, output last_trade, output volume, output status,
                    input ready);
    modport sink   (input valid, input best_bid, input best_ask, input bid_levels,
                    input ask_levels, input last_trade, input volume, input status,
                    output ready);
endinterface

/* rtl/plob_cell.sv */
// One price level of a sorted side: compares against the incoming price and shifts with its neighbors.
module plob_cell #(
    parameter int IDX    = 0,
    parameter bit DESC   = 1'b1,
    parameter int LEVELS = plob_pkg::LEVELS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cap,
    input  logic                         apply,
    input  logic [plob_pkg::PRICE_W-1:0] cmp_price,
    input  logic [$clog2(LEVELS+1)-1:0]  count,
    input  plob_pkg::cell_ctl_t          ctl,
    input  logic                         left_ahead,
    input  plob_pkg::entry_t             left_entry,
    input  plob_pkg::entry_t             right_entry,
    output logic                         ahead,
    output logic                         eq,
    output plob_pkg::entry_t             entry,
    output plob_pkg::entry_t             entry_next
);
    import plob_pkg::*;

    localparam int CW = $clog2(LEVELS + 1);

    entry_t entry_reg;
    logic   ahead_reg;
    logic   eq_reg;
    logic   held;
    logic   ahead_c;
    logic   eq_c;
    logic   at_pos;

    assign held    = CW'(IDX) < count;
    assign ahead_c = held && (DESC ? (entry_reg.price > cmp_price)
                                   : (entry_reg.price < cmp_price));
    assign eq_c    = held && (entry_reg.price == cmp_price);

    // The sorted order makes the ahead flags a prefix, so the insert slot is
    // the first cell that is not ahead while its left neighbor is.
    assign at_pos = !ahead_reg && left_ahead;

    always_comb
    begin
        entry_next = entry_reg;
        case (ctl.act)
            ACT_UPD:
            begin
                if (eq_reg)
                    entry_next.qty = ctl.item.qty;
            end
            ACT_INS:
            begin
                if (at_pos)
                    entry_next = ctl.item;
                else if (!left_ahead)
                    entry_next = left_entry;
            end
            ACT_DEL:
            begin
                if (!ahead_reg)
                    entry_next = right_entry;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ahead_reg <= 1'b0;
            eq_reg    <= 1'b0;
        end
        else if (cap)
        begin
            ahead_reg <= ahead_c;
            eq_reg    <= eq_c;
        end
    end

    always_ff @(posedge clk)
    begin
        if (apply)
            entry_reg <= entry_next;
    end

    assign ahead = ahead_reg;
    assign eq    = eq_reg;
    assign entry = entry_reg;

endmodule

/* rtl/plob_side.sv */
// One side of the book: a row of level cells plus the count and the update decision.
module plob_side #(
    parameter bit DESC   = 1'b1,
    parameter int LEVELS = plob_pkg::LEVELS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cap,
    input  logic                         apply,
    input  logic [plob_pkg::PRICE_W-1:0] cmp_price,
    input  plob_pkg::side_op_t           op,
    input  plob_pkg::entry_t             item,
    output logic [plob_pkg::LVL_W-1:0]   levels,
    output logic [plob_pkg::PRICE_W-1:0] best_next,
    output plob_pkg::status_t            status
);
    import plob_pkg::*;

    localparam int CW = $clog2(LEVELS + 1);

    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic [LEVELS-1:0] ahead;
    logic [LEVELS-1:0] eq;
    entry_t            entries   [LEVELS];
    entry_t            nexts     [LEVELS];
    cell_ctl_t         ctl;
    logic              match;
    logic              full;
    logic              qty_zero;

    assign match    = |eq;
    assign full     = count_reg == CW'(LEVELS);
    assign qty_zero = item.qty == '0;

    always_comb
    begin
        ctl.item   = item;
        ctl.act    = ACT_HOLD;
        status     = STAT_NONE;
        count_next = count_reg;
        case (op)
            SIDE_SET:
            begin
                if (match)
                begin
                    status  = STAT_APPLIED;
                    ctl.act = qty_zero ? ACT_DEL : ACT_UPD;
                end
                else if (qty_zero)
                    status = STAT_NONE;
                else if (full)
                    status = STAT_FULL;
                else
                begin
                    status  = STAT_APPLIED;
                    ctl.act = ACT_INS;
                end
            end
            SIDE_DEL:
            begin
                if (match)
                begin
                    status  = STAT_APPLIED;
                    ctl.act = ACT_DEL;
                end
            end
            default:
            begin
                status = STAT_NONE;
            end
        endcase
        if (ctl.act == ACT_INS)
            count_next = count_reg + CW'(1);
        else if (ctl.act == ACT_DEL)
            count_next = count_reg - CW'(1);
    end

    genvar i;
    generate
        for (i = 0; i < LEVELS; i++)
        begin : g_cell
            logic   left_ahead;
            entry_t left_entry;
            entry_t right_entry;

            if (i == 0)
            begin : g_first
                assign left_ahead = 1'b1;
                assign left_entry = '0;
            end
            else
            begin : g_inner
                assign left_ahead = ahead[i-1];
                assign left_entry = entries[i-1];
            end

            if (i == LEVELS - 1)
            begin : g_last
                assign right_entry = '0;
            end
            else
            begin : g_mid
                assign right_entry = entries[i+1];
            end

            plob_cell #(
                .IDX    (i),
                .DESC   (DESC),
                .LEVELS (LEVELS)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .cap         (cap),
                .apply       (apply),
                .cmp_price   (cmp_price),
                .count       (count_reg),
                .ctl         (ctl),
                .left_ahead  (left_ahead),
                .left_entry  (left_entry),
                .right_entry (right_entry),
                .ahead       (ahead[i]),
                .eq          (eq[i]),
                .entry       (entries[i]),
                .entry_next  (nexts[i])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (apply)
            count_reg <= count_next;
    end

    assign best_next = (count_next != '0) ? nexts[0].price : '0;
    assign levels    = LVL_W'(count_reg);

endmodule

/* rtl/price_level_order_book.sv */
// Price-level order book: two sorted rows of level cells, bids descending and asks ascending.
// An accepted beat is applied and its result registered once no held result waits untaken.
// No new beat is taken until the last is applied; cells compare at acceptance, shift at apply.
// The result register lets a new beat in while the previous result waits to be taken.
// Reset clears level counts, best prices, last trade and volume; level storage needs no reset.
module price_level_order_book #(
    parameter int LEVELS = plob_pkg::LEVELS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    plob_in_if.sink    item,
    plob_out_if.source result
);
    import plob_pkg::*;

    fsm_t               state_reg;
    fsm_t               state_next;
    logic               cap;
    logic               apply;
    logic [2:0]         mode_reg;
    entry_t             item_reg;
    side_op_t           bid_op;
    side_op_t           ask_op;
    logic [PRICE_W-1:0] bid_best_next;
    logic [PRICE_W-1:0] ask_best_next;
    status_t            bid_status;
    status_t            ask_status;
    status_t            status_next;
    logic [PRICE_W-1:0] best_bid_reg;
    logic [PRICE_W-1:0] best_ask_reg;
    logic [PRICE_W-1:0] last_trade_reg;
    logic [PRICE_W-1:0] last_trade_next;
    logic [VOL_W-1:0]   volume_reg;
    logic [VOL_W-1:0]   volume_next;
    logic [VOL_W:0]     volume_sum;
    status_t            status_reg;
    logic               out_valid_reg;

    assign cap = item.valid && item.ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FSM_IDLE:
            begin
                if (item.valid)
                    state_next = FSM_APPLY;
            end
            FSM_APPLY:
            begin
                if (apply)
                    state_next = FSM_IDLE;
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_comb
    begin
        item.ready = 1'b0;
        apply      = 1'b0;
        case (state_reg)
            FSM_IDLE:  item.ready = 1'b1;
            FSM_APPLY: apply      = !out_valid_reg || result.ready;
            default:   item.ready = 1'b0;
        endcase
    end

    always_comb
    begin
        bid_op          = SIDE_IDLE;
        ask_op          = SIDE_IDLE;
        last_trade_next = last_trade_reg;
        volume_next     = volume_reg;
        volume_sum      = {1'b0, volume_reg} + (VOL_W+1)'(item_reg.qty);
        status_next     = STAT_NONE;
        case (mode_reg)
            MODE_SET_BID: bid_op = SIDE_SET;
            MODE_SET_ASK: ask_op = SIDE_SET;
            MODE_DEL_BID: bid_op = SIDE_DEL;
            MODE_DEL_ASK: ask_op = SIDE_DEL;
            MODE_TRADE:
            begin
                last_trade_next = item_reg.price;
                volume_next     = volume_sum[VOL_W] ? '1 : volume_sum[VOL_W-1:0];
                status_next     = STAT_APPLIED;
            end
            default: status_next = STAT_NONE;
        endcase
        if (bid_op != SIDE_IDLE)
            status_next = bid_status;
        else if (ask_op != SIDE_IDLE)
            status_next = ask_status;
    end

    plob_side #(
        .DESC   (1'b1),
        .LEVELS (LEVELS)
    ) u_bid (
        .clk       (clk),
        .rst_n     (rst_n),
        .cap       (cap),
        .apply     (apply),
        .cmp_price (item.price),
        .op        (bid_op),
        .item      (item_reg),
        .levels    (result.bid_levels),
        .best_next (bid_best_next),
        .status    (bid_status)
    );

    plob_side #(
        .DESC   (1'b0),
        .LEVELS (LEVELS)
    ) u_ask (
        .clk       (clk),
        .rst_n     (rst_n),
        .cap       (cap),
        .apply     (apply),
        .cmp_price (item.price),
        .op        (ask_op),
        .item      (item_reg),
        .levels    (result.ask_levels),
        .best_next (ask_best_next),
        .status    (ask_status)
    );

    always_ff @(posedge clk)
    begin
        if (cap)
        begin
            mode_reg       <= item.mode;
            item_reg.price <= item.price;
            item_reg.qty   <= item.quantity;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= FSM_IDLE;
            out_valid_reg  <= 1'b0;
            best_bid_reg   <= '0;
            best_ask_reg   <= '0;
            last_trade_reg <= '0;
            volume_reg     <= '0;
            status_reg     <= STAT_APPLIED;
        end
        else
        begin
            state_reg <= state_next;
            if (apply)
            begin
                out_valid_reg  <= 1'b1;
                best_bid_reg   <= bid_best_next;
                best_ask_reg   <= ask_best_next;
                last_trade_reg <= last_trade_next;
                volume_reg     <= volume_next;
                status_reg     <= status_next;
            end
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.best_bid   = best_bid_reg;
    assign result.best_ask   = best_ask_reg;
    assign result.last_trade = last_trade_reg;
    assign result.volume     = volume_reg;
    assign result.status     = status_reg;

endmodule
